// ===== rtl/tlb_pkg.sv =====
// tlb_pkg: word types and codes shared by the tlb_fifo_lru block and its checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

    localparam int PROC_W  = 16;
    localparam int PAGE_W  = 20;
    localparam int STAMP_W = 32;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 6;

    localparam logic [CFG_IW-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_LIMIT  = 1'b1;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [CFG_DW-1:0]  LIMIT_RESET = 6'd32;
    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;

    typedef struct packed {
        logic              kind;
        logic [PROC_W-1:0] proc_id;
        logic [PAGE_W-1:0] page_num;
        logic [PAGE_W-1:0] frame_in;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] frame_out;
    } t_out_word;

    typedef struct packed {
        logic [PROC_W-1:0]  proc_id;
        logic [PAGE_W-1:0]  page_num;
        logic [PAGE_W-1:0]  frame;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/tlb_fifo_lru.sv =====
// Fully associative TLB keyed by process id and page number, with FIFO or LRU
// replacement. One item is handled at a time: lookups and full-table inserts are
// paced by the scan of the single entry memory at one entry per cycle through its
// one read port. The input is not ready while an item is in work; a finished word
// waits in the output register while a new item is taken.
// Uses tlb_pkg for word types and codes.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_lru #(
    parameter int ENTRIES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire tlb_pkg::t_in_word           i_in_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tlb_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [tlb_pkg::CFG_DW-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output tlb_pkg::t_out_word               o_out_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    tlb_pkg::t_in_word r_item, n_item;
    logic [tlb_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic [tlb_pkg::STAMP_W-1:0] r_clock, n_clock;
    logic [tlb_pkg::STAMP_W-1:0] r_best_stamp, n_best_stamp;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_cnt, n_cnt;
    logic r_policy, n_policy;
    logic [tlb_pkg::CFG_DW-1:0] r_entry_limit, n_entry_limit;
    logic r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [IW-1:0] r_best, n_best;
    logic [IW-1:0] r_widx, n_widx;
    logic r_hit, n_hit;
    logic [tlb_pkg::PAGE_W-1:0] r_frame, n_frame;
    logic r_out_valid, n_out_valid;
    tlb_pkg::t_out_word r_out, n_out;

    tlb_pkg::t_entry mem [ENTRIES];
    tlb_pkg::t_entry r_rd_data;

    logic w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    tlb_pkg::t_entry w_wdata;
    logic [LW-1:0] w_lim;
    logic [LW-1:0] w_new_lim;
    logic w_match;
    logic w_in_acc;
    logic w_cfg_acc;

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_raddr   = r_cnt[IW-1:0];

    assign w_lim = (32'(r_entry_limit) > 32'(ENTRIES)) ? LW'(ENTRIES) : LW'(r_entry_limit);
    assign w_new_lim = (32'(i_cfg_data) > 32'(ENTRIES)) ? LW'(ENTRIES) : LW'(i_cfg_data);
    assign w_match = (r_rd_data.proc_id == r_item.proc_id)
                  && (r_rd_data.page_num == r_item.page_num);

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_stamp       = r_stamp;
        n_clock       = r_clock;
        n_best_stamp  = r_best_stamp;
        n_fill        = r_fill;
        n_cnt         = r_cnt;
        n_policy      = r_policy;
        n_entry_limit = r_entry_limit;
        n_pv          = r_pv;
        n_pidx        = r_pidx;
        n_best        = r_best;
        n_widx        = r_widx;
        n_hit         = r_hit;
        n_frame       = r_frame;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        w_we          = 1'b0;
        w_waddr       = r_widx;
        w_wdata       = '{proc_id: r_item.proc_id, page_num: r_item.page_num,
                          frame: r_item.frame_in, stamp: r_stamp};

        if (w_cfg_acc) begin
            case (i_cfg_index)
                tlb_pkg::CFG_POLICY: n_policy = i_cfg_data[0];
                tlb_pkg::CFG_LIMIT: begin
                    n_entry_limit = i_cfg_data;
                    if (r_fill > w_new_lim) begin
                        n_fill = w_new_lim;
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item  = i_in_data;
                    n_stamp = r_clock;
                    if (r_clock != tlb_pkg::STAMP_MAX) begin
                        n_clock = r_clock + 1'b1;
                    end
                    n_cnt   = '0;
                    n_pv    = 1'b0;
                    n_hit   = 1'b0;
                    n_frame = '0;
                    if (w_lim == '0) begin
                        n_state = S_DONE;
                    end else if (i_in_data.kind == tlb_pkg::KIND_LOOKUP) begin
                        n_state = (r_fill == '0) ? S_DONE : S_SCAN;
                    end else if (r_fill < w_lim) begin
                        n_widx  = r_fill[IW-1:0];
                        n_fill  = r_fill + 1'b1;
                        n_state = S_WRITE;
                    end else if (r_policy == tlb_pkg::POL_FIFO) begin
                        n_cnt   = LW'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pv && r_item.kind == tlb_pkg::KIND_LOOKUP && w_match) begin
                    // hit: refresh the stamp and stop
                    w_we          = 1'b1;
                    w_waddr       = r_pidx;
                    w_wdata       = r_rd_data;
                    w_wdata.stamp = r_stamp;
                    n_hit         = 1'b1;
                    n_frame       = r_rd_data.frame;
                    n_pv          = 1'b0;
                    n_state       = S_DONE;
                end else begin
                    if (r_pv && r_item.kind == tlb_pkg::KIND_INSERT) begin
                        if (r_pidx == '0 || r_rd_data.stamp < r_best_stamp) begin
                            n_best       = r_pidx;
                            n_best_stamp = r_rd_data.stamp;
                        end
                    end
                    if (r_cnt != r_fill) begin
                        n_cnt  = r_cnt + 1'b1;
                        n_pv   = 1'b1;
                        n_pidx = r_cnt[IW-1:0];
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            if (r_item.kind == tlb_pkg::KIND_LOOKUP) begin
                                n_state = S_DONE;
                            end else begin
                                n_widx  = r_best;
                                n_state = S_WRITE;
                            end
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = r_pidx - 1'b1;
                    w_wdata = r_rd_data;
                end
                if (r_cnt != r_fill) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_widx  = IW'(r_fill - 1'b1);
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_widx;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.hit       = r_hit;
                    n_out.frame_out = r_frame;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clock       <= '0;
            r_fill        <= '0;
            r_cnt         <= '0;
            r_policy      <= tlb_pkg::POL_FIFO;
            r_entry_limit <= tlb_pkg::LIMIT_RESET;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clock       <= n_clock;
            r_fill        <= n_fill;
            r_cnt         <= n_cnt;
            r_policy      <= n_policy;
            r_entry_limit <= n_entry_limit;
            r_pv          <= n_pv;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_stamp      <= n_stamp;
        r_best_stamp <= n_best_stamp;
        r_pidx       <= n_pidx;
        r_best       <= n_best;
        r_widx       <= n_widx;
        r_hit        <= n_hit;
        r_frame      <= n_frame;
        r_out        <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/tlb_chk.sv =====
// tlb_chk: port-level assertions for tlb_fifo_lru, attached by bind
// depends on tlb_pkg and the tlb_fifo_lru ports
`timescale 1ns / 1ps
`default_nettype none

module tlb_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tlb_pkg::t_out_word o_out_data
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a miss carries a zero frame
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.frame_out == '0)
        else $error("miss with nonzero frame");

    // config and item never taken together
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && o_in_ready))
        else $error("config write and item accepted together");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind tlb_fifo_lru tlb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/tb_tlb_fifo_lru.sv =====
// tb: self-checking bench for the tlb_fifo_lru lookup and replace block
// drives lookups and inserts through valid/ready and mirrors the table in a scoreboard
// depends on tlb_pkg and rtl/tlb_fifo_lru.sv
`timescale 1ns / 1ps

module tb;

    localparam int TLB_DEPTH    = 32;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 14;
    localparam int PHASE_WORDS  = 134;
    localparam int PROC_W       = tlb_pkg::PROC_W;
    localparam int PAGE_W       = tlb_pkg::PAGE_W;
    localparam int CFG_DW       = tlb_pkg::CFG_DW;
    localparam int KEY_W        = PROC_W + PAGE_W;

    class tlb_scoreboard;
        tlb_pkg::t_entry                tbl[TLB_DEPTH];
        int unsigned                    fill;
        logic [tlb_pkg::STAMP_W-1:0]    use_clk;
        logic                           policy;
        logic [CFG_DW-1:0]              limit;
        tlb_pkg::t_out_word             expected_q[$];
        int unsigned                    mismatches;

        function new();
            fill       = 0;
            use_clk    = '0;
            policy     = tlb_pkg::POL_FIFO;
            limit      = tlb_pkg::LIMIT_RESET;
            mismatches = 0;
        endfunction

        function int unsigned active_limit();
            return (32'(limit) > TLB_DEPTH) ? TLB_DEPTH : 32'(limit);
        endfunction

        function void write_reg(logic [tlb_pkg::CFG_IW-1:0] idx,
                                logic [CFG_DW-1:0] val);
            if (idx == tlb_pkg::CFG_POLICY) begin
                policy = val[0];
            end else begin
                limit = val;
                if (fill > active_limit())
                    fill = active_limit();
            end
        endfunction

        function void note_word(tlb_pkg::t_in_word w);
            int unsigned                 lim;
            int unsigned                 n;
            int unsigned                 victim;
            int unsigned                 i;
            logic [tlb_pkg::STAMP_W-1:0] stamp;
            tlb_pkg::t_entry             fresh;
            tlb_pkg::t_out_word          res;
            lim    = active_limit();
            stamp  = use_clk;
            n      = (fill > lim) ? lim : fill;
            res    = '0;
            fresh.proc_id  = w.proc_id;
            fresh.page_num = w.page_num;
            fresh.frame    = w.frame_in;
            fresh.stamp    = stamp;
            if (use_clk != tlb_pkg::STAMP_MAX)
                use_clk = use_clk + 1;
            if (lim != 0) begin
                if (w.kind == tlb_pkg::KIND_LOOKUP) begin
                    for (i = 0; i < n && !res.hit; i++) begin
                        if (tbl[i].proc_id == w.proc_id && tbl[i].page_num == w.page_num) begin
                            tbl[i].stamp  = stamp;
                            res.hit       = 1'b1;
                            res.frame_out = tbl[i].frame;
                        end
                    end
                end else if (n < lim) begin
                    tbl[n] = fresh;
                    fill   = n + 1;
                end else if (policy == tlb_pkg::POL_FIFO) begin
                    for (i = 1; i < n; i++)
                        tbl[i-1] = tbl[i];
                    tbl[n-1] = fresh;
                end else begin
                    victim = 0;
                    for (i = 1; i < n; i++) begin
                        if (tbl[i].stamp < tbl[victim].stamp)
                            victim = i;
                    end
                    tbl[victim] = fresh;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_word(tlb_pkg::t_out_word got);
            tlb_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: hit=%0d frame=%h", got.hit, got.frame_out);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit || got.frame_out !== want.frame_out) begin
                if (mismatches < 10)
                    $display("mismatch at %0t: expected hit=%0d frame=%h, got hit=%0d frame=%h",
                             $realtime, want.hit, want.frame_out, got.hit, got.frame_out);
                mismatches++;
            end
        endfunction

        function int unsigned waiting();
            return expected_q.size();
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    tlb_pkg::t_in_word             i_in_data   = '0;
    logic                          i_cfg_valid = 1'b0;
    logic [tlb_pkg::CFG_IW-1:0]    i_cfg_index = tlb_pkg::CFG_POLICY;
    logic [CFG_DW-1:0]             i_cfg_data  = '0;
    logic                          i_out_ready = 1'b0;
    logic                          o_in_ready;
    logic                          o_cfg_ready;
    logic                          o_out_valid;
    tlb_pkg::t_out_word            o_out_data;

    tlb_scoreboard       sb = new();
    logic [KEY_W-1:0]    key_pool[$];
    bit                  quiet      = 1'b0;
    int unsigned         gap_odds   = 0;
    int unsigned         stall_odds = 0;
    int unsigned         stall_left = 0;

    tlb_fifo_lru #(
        .ENTRIES(TLB_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_out_data);
    end

    task automatic send_word(logic kind, logic [PROC_W-1:0] proc,
                             logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] frame);
        tlb_pkg::t_in_word w;
        w.kind     = kind;
        w.proc_id  = proc;
        w.page_num = page;
        w.frame_in = frame;
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    task automatic write_reg(logic [tlb_pkg::CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(logic pol, logic [CFG_DW-1:0] lim);
        drain();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(tlb_pkg::CFG_POLICY, {{(CFG_DW-1){1'b0}}, pol});
            write_reg(tlb_pkg::CFG_LIMIT, lim);
        end else begin
            write_reg(tlb_pkg::CFG_LIMIT, lim);
            write_reg(tlb_pkg::CFG_POLICY, {{(CFG_DW-1){1'b0}}, pol});
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        logic              kind;
        logic [KEY_W-1:0]  key;
        int unsigned       pick;
        kind = ($urandom_range(0, 99) < 45) ? tlb_pkg::KIND_INSERT : tlb_pkg::KIND_LOOKUP;
        pick = $urandom_range(0, 9);
        if (key_pool.size() != 0 && pick < 5)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 8)
            key = {PROC_W'($urandom_range(0, 3)), PAGE_W'($urandom_range(0, 7))};
        else
            key = {PROC_W'($urandom), PAGE_W'($urandom)};
        if (kind == tlb_pkg::KIND_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
        send_word(kind, key[KEY_W-1:PAGE_W], key[PAGE_W-1:0], PAGE_W'($urandom));
    endtask

    initial begin
        logic              pol;
        logic [CFG_DW-1:0] lim;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, duplicates
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0000, 20'h00000, 20'hfffff);
        send_word(tlb_pkg::KIND_INSERT, 16'h0000, 20'h00000, 20'h00000);
        send_word(tlb_pkg::KIND_INSERT, 16'hffff, 20'hfffff, 20'hfffff);
        send_word(tlb_pkg::KIND_INSERT, 16'hffff, 20'hfffff, 20'h5a5a5);
        send_word(tlb_pkg::KIND_LOOKUP, 16'hffff, 20'hfffff, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0000, 20'hfffff, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'hffff, 20'h00000, 20'h00000);

        // limit cut below fill, lru victim choice
        set_mode(tlb_pkg::POL_LRU, 6'd2);
        send_word(tlb_pkg::KIND_LOOKUP, 16'hffff, 20'hfffff, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0001, 20'h00001, 20'h00000);
        send_word(tlb_pkg::KIND_INSERT, 16'h0001, 20'h00001, 20'h11111);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0001, 20'h00001, 20'h00000);
        send_word(tlb_pkg::KIND_INSERT, 16'h0002, 20'h00002, 20'h22222);
        send_word(tlb_pkg::KIND_LOOKUP, 16'hffff, 20'hfffff, 20'h00000);

        // policy switch keeps entries, fifo shift
        set_mode(tlb_pkg::POL_FIFO, 6'd2);
        send_word(tlb_pkg::KIND_INSERT, 16'h0003, 20'h00003, 20'h33333);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0001, 20'h00001, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0002, 20'h00002, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0003, 20'h00003, 20'h00000);

        // disabled table
        set_mode(tlb_pkg::POL_LRU, 6'd0);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0002, 20'h00002, 20'h00000);
        send_word(tlb_pkg::KIND_INSERT, 16'h0004, 20'h00004, 20'h44444);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0004, 20'h00004, 20'h00000);

        // limit above table size
        set_mode(tlb_pkg::POL_FIFO, 6'd63);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h0002, 20'h00002, 20'h00000);
        send_word(tlb_pkg::KIND_INSERT, 16'haaaa, 20'haaaaa, 20'h55555);
        send_word(tlb_pkg::KIND_LOOKUP, 16'haaaa, 20'haaaaa, 20'h00000);
        send_word(tlb_pkg::KIND_LOOKUP, 16'h5555, 20'h55555, 20'h00000);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin pol = tlb_pkg::POL_LRU;  lim = 6'd32; end
                1: begin pol = tlb_pkg::POL_FIFO; lim = 6'd1;  end
                2: begin pol = tlb_pkg::POL_LRU;  lim = 6'd1;  end
                3: begin pol = tlb_pkg::POL_FIFO; lim = 6'd0;  end
                4: begin pol = tlb_pkg::POL_LRU;  lim = 6'd63; end
                5: begin pol = tlb_pkg::POL_FIFO; lim = 6'd33; end
                6: begin pol = tlb_pkg::POL_LRU;  lim = 6'd3;  end
                default: begin
                    pol = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 2))
                        0: lim = CFG_DW'($urandom_range(1, 8));
                        1: lim = CFG_DW'($urandom_range(9, 32));
                        default: lim = CFG_DW'($urandom_range(33, 63));
                    endcase
                end
            endcase
            set_mode(pol, lim);
            quiet = (ph == PHASES - 1);
            case ($urandom_range(0, 3))
                0: begin gap_odds = 0; stall_odds = 0; end
                1: begin gap_odds = 3; stall_odds = 0; end
                2: begin gap_odds = 0; stall_odds = 6; end
                default: begin gap_odds = 4; stall_odds = 8; end
            endcase
            repeat (PHASE_WORDS) random_word();
        end

        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.waiting() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tlb_pkg.sv
rtl/tlb_fifo_lru.sv
rtl/tlb_chk.sv
tb/tb_tlb_fifo_lru.sv
